[src/tdvu_pkg.sv]
package tdvu_pkg;

	typedef logic signed [31:0] value_t;
	typedef logic [16:0] rate_t;
	typedef logic [3:0] row_t;
	typedef logic [7:0] gene_vec_t;
	typedef logic [0:0] cfg_index_t;

	localparam cfg_index_t CFG_LEARNING_RATE   = 1'b0;
	localparam cfg_index_t CFG_DISCOUNT_FACTOR = 1'b1;

	localparam rate_t ONE_Q16            = 17'h10000;
	localparam rate_t LEARNING_RATE_RST  = 17'd6554;
	localparam rate_t DISCOUNT_RST       = 17'd58982;

	localparam value_t VALUE_MAX = 32'sh7FFF_FFFF;
	localparam value_t VALUE_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic mul1;
		logic sub;
		logic mul2;
	} arith_ctl_t;

endpackage

[src/tdvu_item_if.sv]
interface tdvu_item_if;
	import tdvu_pkg::*;

	logic      valid;
	logic      ready;
	logic      action;
	row_t      row;
	gene_vec_t state_bits;
	gene_vec_t next_state_bits;
	value_t    reward;

	modport source (output valid, action, row, state_bits, next_state_bits, reward,
		input ready);
	modport sink (input valid, action, row, state_bits, next_state_bits, reward,
		output ready);
endinterface

[src/tdvu_result_if.sv]
interface tdvu_result_if;
	import tdvu_pkg::*;

	logic   valid;
	logic   ready;
	value_t value;
	logic   saturated;

	modport source (output valid, value, saturated, input ready);
	modport sink (input valid, value, saturated, output ready);
endinterface

[src/td_value_table_update.sv]
// Temporal-difference value table: ROWS rows of 2^GENES signed Q16.16 values in one
// synchronous RAM with a single read and a single write port. A query result is registered
// from the RAM read in ST_RD; an update goes through ST_RD, ST_TD, ST_MUL2 and ST_FIN before
// its result is registered, since the successor and current entries are read one after the
// other through the one read port and the discount and learning-rate multiplies run in
// separate stages. Items are processed one at a time: a new transaction is taken only once
// the previous one is back in ST_IDLE. The next transaction may be accepted while the
// previous result still waits for the receiver; it then holds before its own result until
// the output register frees up. After reset the table is cleared one entry per cycle, all
// ROWS * 2^GENES entries (4096 with the defaults), during which no item is accepted;
// configuration writes are taken at any time.
module td_value_table_update #(
	parameter int ROWS  = 16,
	parameter int GENES = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  tdvu_pkg::cfg_index_t  cfg_index,
	input  tdvu_pkg::rate_t       cfg_data,
	tdvu_item_if.sink             item,
	tdvu_result_if.source         result
);
	import tdvu_pkg::*;

	localparam int DEPTH = ROWS * (2 ** GENES);
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [15:0] STATE_MASK = 16'((2 ** GENES) - 1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RD   = 5'b00010,
		ST_TD   = 5'b00100,
		ST_MUL2 = 5'b01000,
		ST_FIN  = 5'b10000
	} fsm_t;

	fsm_t          state_q, state_d;
	logic          clear_q;
	logic [AW-1:0] clr_cnt_q;
	rate_t         lr_q, df_q;
	rate_t         cfg_clamped;
	logic          action_q;
	logic          row_ok_q;
	logic [AW-1:0] s_addr_q;
	value_t        reward_q;
	logic          res_valid_q;
	value_t        value_q;
	logic          saturated_q;

	logic          accept;
	logic          row_ok_in;
	logic [24:0]   s_full, n_full;
	logic [AW-1:0] s_addr_in, n_addr_in;
	logic          out_free;
	logic          ram_re, ram_we;
	logic [AW-1:0] ram_raddr, ram_waddr;
	value_t        ram_wdata, ram_rdata;
	arith_ctl_t    ctl;
	value_t        new_value;
	logic          new_sat;
	logic          load_res;
	value_t        res_value;
	logic          res_sat;

	assign item.ready = (state_q == ST_IDLE) && !clear_q;
	assign accept     = item.valid && item.ready;
	assign out_free   = !res_valid_q || result.ready;

	assign row_ok_in = {5'b0, item.row} < 9'(ROWS);
	assign s_full    = (25'(item.row) << GENES) | 25'({8'b0, item.state_bits} & STATE_MASK);
	assign n_full    = (25'(item.row) << GENES)
		| 25'({8'b0, item.next_state_bits} & STATE_MASK);
	assign s_addr_in = row_ok_in ? s_full[AW-1:0] : '0;
	assign n_addr_in = row_ok_in ? n_full[AW-1:0] : '0;

	assign cfg_clamped = (cfg_data > ONE_Q16) ? ONE_Q16 : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q <= LEARNING_RATE_RST;
			df_q <= DISCOUNT_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_LEARNING_RATE:   lr_q <= cfg_clamped;
				CFG_DISCOUNT_FACTOR: df_q <= cfg_clamped;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q   <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clear_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == AW'(DEPTH - 1)) begin
				clear_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		ram_re   = 1'b0;
		ram_we   = 1'b0;
		load_res = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ram_re  = 1'b1;
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				if (!action_q || !row_ok_q) begin
					if (out_free) begin
						load_res = 1'b1;
						state_d  = ST_IDLE;
					end
				end else begin
					ctl.mul1 = 1'b1;
					ram_re   = 1'b1;
					state_d  = ST_TD;
				end
			end
			ST_TD: begin
				ctl.sub = 1'b1;
				state_d = ST_MUL2;
			end
			ST_MUL2: begin
				ctl.mul2 = 1'b1;
				state_d  = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					ram_we   = 1'b1;
					load_res = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (clear_q) begin
			ram_we = 1'b1;
		end
	end

	assign ram_raddr = (state_q == ST_IDLE) ? (item.action ? n_addr_in : s_addr_in) : s_addr_q;
	assign ram_waddr = clear_q ? clr_cnt_q : s_addr_q;
	assign ram_wdata = clear_q ? '0 : new_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= item.action;
			row_ok_q <= row_ok_in;
			s_addr_q <= s_addr_in;
			reward_q <= item.reward;
		end
	end

	tdvu_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	tdvu_arith u_arith (
		.clk      (clk),
		.ctl      (ctl),
		.alpha    (lr_q),
		.gamma    (df_q),
		.reward   (reward_q),
		.rd_data  (ram_rdata),
		.new_value(new_value),
		.saturated(new_sat)
	);

	assign res_value = (state_q == ST_FIN) ? new_value : (row_ok_q ? ram_rdata : '0);
	assign res_sat   = (state_q == ST_FIN) ? new_sat : 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			value_q     <= res_value;
			saturated_q <= res_sat;
		end
	end

	assign result.valid     = res_valid_q;
	assign result.value     = value_q;
	assign result.saturated = saturated_q;

	assert property (@(posedge clk) disable iff (!arst_n) clear_q |-> !item.ready)
		else $error("item accepted during table clear");

	assert property (@(posedge clk) disable iff (!arst_n) accept |=> state_q == ST_RD)
		else $error("accepted transaction did not start a read");

	assert property (@(posedge clk) disable iff (!arst_n) lr_q <= ONE_Q16 && df_q <= ONE_Q16)
		else $error("rate register above one");

	assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && !clear_q) |-> (row_ok_q && action_q && state_q == ST_FIN))
		else $error("table written outside an in-range update");
endmodule

[src/tdvu_ram.sv]
module tdvu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

[src/tdvu_arith.sv]
module tdvu_arith (
	input  logic                clk,
	input  tdvu_pkg::arith_ctl_t ctl,
	input  tdvu_pkg::rate_t     alpha,
	input  tdvu_pkg::rate_t     gamma,
	input  tdvu_pkg::value_t    reward,
	input  tdvu_pkg::value_t    rd_data,
	output tdvu_pkg::value_t    new_value,
	output logic                saturated
);
	import tdvu_pkg::*;

	logic signed [49:0] prod1_s1;
	logic signed [49:0] g_sum;
	logic signed [33:0] g;
	logic signed [34:0] td;
	logic signed [34:0] td_s2;
	value_t             vs_s2;
	logic signed [52:0] prod2_s3;
	value_t             vs_s3;
	logic signed [52:0] d_sum;
	logic signed [36:0] delta;
	logic signed [37:0] nv;

	assign g_sum = prod1_s1 + 50'sd32768;
	assign g     = $signed(g_sum[49:16]);
	assign td    = 35'(reward) + 35'(g) - 35'(rd_data);

	always_ff @(posedge clk) begin
		if (ctl.mul1) begin
			prod1_s1 <= $signed({1'b0, gamma}) * rd_data;
		end
		if (ctl.sub) begin
			td_s2 <= td;
			vs_s2 <= rd_data;
		end
		if (ctl.mul2) begin
			prod2_s3 <= $signed({1'b0, alpha}) * td_s2;
			vs_s3    <= vs_s2;
		end
	end

	assign d_sum = prod2_s3 + 53'sd32768;
	assign delta = $signed(d_sum[52:16]);
	assign nv    = 38'(vs_s3) + 38'(delta);

	always_comb begin
		saturated = 1'b0;
		new_value = nv[31:0];
		if (nv > 38'(VALUE_MAX)) begin
			new_value = VALUE_MAX;
			saturated = 1'b1;
		end else if (nv < 38'(VALUE_MIN)) begin
			new_value = VALUE_MIN;
			saturated = 1'b1;
		end
	end
endmodule

[tb/tb_td_value_table_update.sv]
`timescale 1ns / 100ps

module tb_td_value_table_update;
	import tdvu_pkg::*;

	localparam int   TABLE_SIZE = 16 * 256;
	localparam logic ACT_QUERY  = 1'b0;
	localparam logic ACT_UPDATE = 1'b1;
	localparam int   PHASE_ITEMS = 150;

	typedef struct {
		logic      action;
		row_t      row;
		gene_vec_t state_bits;
		gene_vec_t next_state_bits;
		value_t    reward;
	} td_item_t;

	typedef struct {
		value_t value;
		logic   saturated;
	} td_outcome_t;

	class td_ledger;
		int          vtab[TABLE_SIZE];
		rate_t       alpha;
		rate_t       gamma;
		td_outcome_t owed[$];
		int          errors;
		int          mismatches;
		int          checked;
		int          updates;
		int          sat_seen;

		function new();
			alpha = LEARNING_RATE_RST;
			gamma = DISCOUNT_RST;
			errors = 0;
			mismatches = 0;
			checked = 0;
			updates = 0;
			sat_seen = 0;
		endfunction

		function void set_rate(cfg_index_t idx, rate_t v);
			rate_t c;
			c = (v > ONE_Q16) ? ONE_Q16 : v;
			if (idx == CFG_LEARNING_RATE) begin
				alpha = c;
			end else begin
				gamma = c;
			end
		endfunction

		function void note_item(td_item_t t);
			td_outcome_t o;
			int          idx_s;
			int          idx_n;
			longint      vs;
			longint      vn;
			longint      g;
			longint      td;
			longint      delta;
			longint      nv;
			idx_s = int'({t.row, t.state_bits});
			idx_n = int'({t.row, t.next_state_bits});
			vs = longint'(vtab[idx_s]);
			o.value = vs[31:0];
			o.saturated = 1'b0;
			if (t.action == ACT_UPDATE) begin
				vn = longint'(vtab[idx_n]);
				g = (longint'(gamma) * vn + 32768) >>> 16;
				td = longint'(t.reward) + g - vs;
				delta = (longint'(alpha) * td + 32768) >>> 16;
				nv = vs + delta;
				if (nv > longint'(VALUE_MAX)) begin
					nv = longint'(VALUE_MAX);
					o.saturated = 1'b1;
				end else if (nv < longint'(VALUE_MIN)) begin
					nv = longint'(VALUE_MIN);
					o.saturated = 1'b1;
				end
				vtab[idx_s] = int'(nv);
				o.value = nv[31:0];
				updates++;
			end
			owed.push_back(o);
		endfunction

		function void check_result(value_t v, logic sat);
			td_outcome_t o;
			if (owed.size() == 0) begin
				errors++;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: value %h saturated %b", v, sat);
				return;
			end
			o = owed.pop_front();
			checked++;
			if (sat === 1'b1)
				sat_seen++;
			if (v !== o.value || sat !== o.saturated) begin
				errors++;
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: value exp %h got %h, saturated exp %b got %b",
						o.value, v, o.saturated, sat);
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_write;
	cfg_index_t cfg_index;
	rate_t      cfg_data;
	bit         no_idle;
	td_ledger   ledger;

	tdvu_item_if   item_ch();
	tdvu_result_if result_ch();

	td_value_table_update dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_ch),
		.result    (result_ch)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#500_000;
		$display("tb_td_value_table_update: done, errors");
		$finish;
	end

	function automatic td_item_t make_item(logic a, row_t r, gene_vec_t s, gene_vec_t sn,
		value_t rw);
		td_item_t t;
		t.action = a;
		t.row = r;
		t.state_bits = s;
		t.next_state_bits = sn;
		t.reward = rw;
		return t;
	endfunction

	function automatic gene_vec_t pick_state();
		gene_vec_t s;
		if ($urandom_range(3) == 0) begin
			s = gene_vec_t'($urandom);
		end else begin
			s = gene_vec_t'($urandom_range(7));
			if ($urandom_range(1))
				s = s | 8'hF0;
		end
		return s;
	endfunction

	function automatic value_t pick_reward();
		value_t rw;
		case ($urandom_range(9))
			0: rw = VALUE_MAX;
			1: rw = VALUE_MIN;
			2: rw = '0;
			3, 4: rw = value_t'($urandom);
			default: rw = $signed($urandom_range(0, 4194304)) - 2097152;
		endcase
		return rw;
	endfunction

	function automatic td_item_t random_item();
		td_item_t t;
		t.action = ($urandom_range(99) < 70) ? ACT_UPDATE : ACT_QUERY;
		t.row = $urandom_range(1) ? row_t'($urandom_range(3)) : row_t'($urandom);
		t.state_bits = pick_state();
		t.next_state_bits = ($urandom_range(9) == 0) ? t.state_bits : pick_state();
		t.reward = pick_reward();
		return t;
	endfunction

	task automatic send_item(td_item_t t);
		if (!no_idle && $urandom_range(99) < 32) begin
			item_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 32);
		end
		item_ch.valid <= 1'b1;
		item_ch.action <= t.action;
		item_ch.row <= t.row;
		item_ch.state_bits <= t.state_bits;
		item_ch.next_state_bits <= t.next_state_bits;
		item_ch.reward <= t.reward;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		ledger.note_item(t);
	endtask

	task automatic drain_results();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (ledger.owed.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic configure(rate_t lr, rate_t df);
		cfg_write <= 1'b1;
		cfg_index <= CFG_LEARNING_RATE;
		cfg_data <= lr;
		@(posedge clk);
		cfg_index <= CFG_DISCOUNT_FACTOR;
		cfg_data <= df;
		@(posedge clk);
		cfg_write <= 1'b0;
		ledger.set_rate(CFG_LEARNING_RATE, lr);
		ledger.set_rate(CFG_DISCOUNT_FACTOR, df);
	endtask

	task automatic directed_items();
		send_item(make_item(ACT_QUERY, 4'd0, 8'h00, 8'h00, '0));
		send_item(make_item(ACT_QUERY, 4'd15, 8'hFF, 8'hFF, VALUE_MIN));
		send_item(make_item(ACT_UPDATE, 4'd15, 8'hFF, 8'hFF, VALUE_MAX));
		send_item(make_item(ACT_UPDATE, 4'd15, 8'hFF, 8'h00, VALUE_MIN));
		send_item(make_item(ACT_UPDATE, 4'd0, 8'h00, 8'hFF, '0));
		send_item(make_item(ACT_QUERY, 4'd15, 8'hFF, 8'h00, VALUE_MAX));
		drain_results();
		configure(ONE_Q16, ONE_Q16);
		send_item(make_item(ACT_UPDATE, 4'd1, 8'h01, 8'h02, VALUE_MAX));
		send_item(make_item(ACT_UPDATE, 4'd1, 8'h03, 8'h01, VALUE_MAX));
		send_item(make_item(ACT_QUERY, 4'd1, 8'h03, 8'h00, '0));
		send_item(make_item(ACT_UPDATE, 4'd1, 8'h04, 8'h05, VALUE_MIN));
		send_item(make_item(ACT_UPDATE, 4'd1, 8'h06, 8'h04, VALUE_MIN));
		send_item(make_item(ACT_QUERY, 4'd1, 8'h06, 8'h00, '0));
		send_item(make_item(ACT_UPDATE, 4'd1, 8'h03, 8'h03, VALUE_MIN));
		send_item(make_item(ACT_UPDATE, 4'd2, 8'hAA, 8'h55, 32'sh0000_8000));
		send_item(make_item(ACT_UPDATE, 4'd2, 8'h55, 8'hAA, -32'sd32768));
		drain_results();
		configure('0, '0);
		send_item(make_item(ACT_UPDATE, 4'd1, 8'h03, 8'h01, VALUE_MAX));
		send_item(make_item(ACT_QUERY, 4'd1, 8'h03, 8'h00, '0));
	endtask

	initial begin
		int seen;
		int hold_left;
		bit held;
		seen = 0;
		hold_left = 0;
		held = 1'b0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
				ledger.check_result(result_ch.value, result_ch.saturated);
				seen++;
			end
			if (!held && seen == 200) begin
				held = 1'b1;
				hold_left = 250;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= no_idle || ($urandom_range(99) >= 32);
			end
		end
	end

	initial begin
		rate_t lr_set[6];
		rate_t df_set[6];
		rate_t lr;
		rate_t df;
		lr_set = '{ONE_Q16, 17'd0, 17'd131071, LEARNING_RATE_RST, 17'd0, 17'd1};
		df_set = '{ONE_Q16, 17'd0, 17'd100000, DISCOUNT_RST, 17'd0, 17'd65535};
		ledger = new();
		no_idle = 1'b0;
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= CFG_LEARNING_RATE;
		cfg_data <= '0;
		item_ch.valid <= 1'b0;
		item_ch.action <= ACT_QUERY;
		item_ch.row <= '0;
		item_ch.state_bits <= '0;
		item_ch.next_state_bits <= '0;
		item_ch.reward <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_items();
		for (int p = 0; p < 6; p++) begin
			drain_results();
			lr = lr_set[p];
			df = df_set[p];
			if (p == 4) begin
				lr = rate_t'($urandom_range(131071));
				df = rate_t'($urandom_range(131071));
			end
			configure(lr, df);
			no_idle = (p == 3);
			repeat (PHASE_ITEMS) send_item(random_item());
		end
		no_idle = 1'b0;
		drain_results();
		repeat (12) @(posedge clk);
		$display("run covered: %0d results checked, %0d updates, %0d saturated, %0d mismatches",
			ledger.checked, ledger.updates, ledger.sat_seen, ledger.mismatches);
		$display("run covered: rates swept from 0 to 1.0, clamped writes and reset values");
		if (ledger.errors == 0 && ledger.owed.size() == 0) begin
			$display("tb_td_value_table_update: done, clean");
		end else begin
			$display("tb_td_value_table_update: done, errors");
		end
		$finish;
	end

endmodule

[td_value_table_update.f]
src/tdvu_pkg.sv
src/tdvu_item_if.sv
src/tdvu_result_if.sv
src/tdvu_ram.sv
src/tdvu_arith.sv
src/td_value_table_update.sv
tb/tb_td_value_table_update.sv
